/* rtl/core/cdad_pkg.sv */
// Shared types, constants and calendar tables for the date-add-days core.
`timescale 1ns / 1ps

package cdad_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ADD_W   = 16;
  localparam int ERR_W   = 2;
  localparam int CUM_W   = 9;
  localparam int QUO_W   = 8;
  localparam int MOD_W   = 7;

  localparam int DEF_MAX_ADD_DAYS = 65535;

  localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd16383;
  localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
  localparam logic [MOD_W-1:0]   MOD100_LAST  = 7'd99;

  // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for every 14-bit y
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV100_PROD_W = 28;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_INVALID  = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_RESIDUE,
    ST_CHECK,
    ST_YEARS,
    ST_MONTHS,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;         // capture a new start date
    logic residue;      // form year mod 100 and century mod 4
    logic check;        // validate and build the day-of-year count plus offset
    logic year_step;    // drop one whole year
    logic overflow;     // year ran past the field range
    logic month_start;  // begin the month walk at January
    logic month_step;   // drop one whole month
    logic out_load;     // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic year_more;
    logic year_last;
    logic month_more;
  } sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before m of a common year
  function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [CUM_W-1:0] c;
    unique case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/cdad_ctrl.sv */
// Sequencer for the date-add-days core: walks load, residue, check, year, month and output phases.
`timescale 1ns / 1ps

module cdad_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  cdad_pkg::sts_t sts,
  output cdad_pkg::cmd_t cmd
);
  import cdad_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_DIVIDE;
      ST_DIVIDE:  state_nxt = ST_RESIDUE;
      ST_RESIDUE: state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = sts.invalid ? ST_FINISH : ST_YEARS;
      ST_YEARS: begin
        if (!sts.year_more) begin
          state_nxt = ST_MONTHS;
        end else if (sts.year_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_MONTHS:  if (!sts.month_more) state_nxt = ST_FINISH;
      ST_FINISH:  if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    unique case (state_r)
      ST_IDLE:    cmd.load = in_valid;
      ST_DIVIDE:  cmd.residue = 1'b1;
      ST_RESIDUE: cmd.check = 1'b0;
      ST_CHECK:   cmd.check = 1'b1;
      ST_YEARS: begin
        cmd.year_step   = sts.year_more && !sts.year_last;
        cmd.overflow    = sts.year_more && sts.year_last;
        cmd.month_start = !sts.year_more;
      end
      ST_MONTHS:  cmd.month_step = sts.month_more;
      ST_FINISH:  cmd.out_load = out_free;
      default:    cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/cdad_dpath.sv */
// Datapath for the date-add-days core: working date, day count, leap tracking.
`timescale 1ns / 1ps

module cdad_dpath #(
  parameter int MAX_ADD_DAYS = cdad_pkg::DEF_MAX_ADD_DAYS
) (
  input  logic                          clk,
  input  logic [cdad_pkg::YEAR_W-1:0]   in_year,
  input  logic [cdad_pkg::MONTH_W-1:0]  in_month,
  input  logic [cdad_pkg::DAY_W-1:0]    in_day,
  input  logic [cdad_pkg::ADD_W-1:0]    in_add_days,
  input  cdad_pkg::cmd_t                cmd,
  output cdad_pkg::sts_t                sts,
  output logic [cdad_pkg::YEAR_W-1:0]   out_new_year,
  output logic [cdad_pkg::MONTH_W-1:0]  out_new_month,
  output logic [cdad_pkg::DAY_W-1:0]    out_new_day,
  output logic [cdad_pkg::ERR_W-1:0]    out_error_code
);
  import cdad_pkg::*;

  localparam int OFS_W = $clog2(MAX_ADD_DAYS + 1);
  localparam int CNT_W = $clog2(MAX_ADD_DAYS + 367);

  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   day_r;
  logic [OFS_W-1:0]   ofs_r;
  logic [QUO_W-1:0]   quo_r;
  logic [MOD_W-1:0]   mod100_r;
  logic [1:0]         cent4_r;
  logic [CNT_W-1:0]   cnt_r;
  err_t               err_r;

  logic [YEAR_W-1:0]  res_year_r;
  logic [MONTH_W-1:0] res_month_r;
  logic [DAY_W-1:0]   res_day_r;
  err_t               res_err_r;

  logic [DIV100_PROD_W-1:0] quo_prod;
  logic [31:0]              ofs_ext, ofs_sat;
  logic [YEAR_W-1:0]        hundreds;
  logic [YEAR_W-1:0]        residue;
  logic                     leap;
  logic [DAY_W-1:0]         mlen;
  logic [CNT_W-1:0]         ylen;
  logic [CNT_W-1:0]         mlen_ext;
  logic [CNT_W-1:0]         start_cnt;
  logic                     leap_adj;

  assign quo_prod = DIV100_PROD_W'(in_year) * DIV100_PROD_W'(DIV100_MUL);
  assign ofs_ext  = 32'(in_add_days);
  assign ofs_sat  = (ofs_ext > 32'(MAX_ADD_DAYS)) ? 32'(MAX_ADD_DAYS) : ofs_ext;

  assign hundreds = YEAR_W'(quo_r) * YEAR_W'(100);
  assign residue  = year_r - hundreds;

  assign leap     = (mod100_r == '0) ? (cent4_r == 2'd0) : (year_r[1:0] == 2'd0);
  assign mlen     = month_len(month_r, leap);
  assign mlen_ext = CNT_W'(mlen);
  assign ylen     = leap ? CNT_W'(366) : CNT_W'(365);
  assign leap_adj = leap && (month_r > MONTH_FEB);

  assign start_cnt = CNT_W'(day_r) + CNT_W'(cum_days(month_r)) + CNT_W'(leap_adj)
                   + CNT_W'(ofs_r);

  assign sts.invalid    = (month_r < MONTH_JAN) || (month_r > MONTH_DEC) ||
                          (day_r == '0) || (day_r > mlen);
  assign sts.year_more  = cnt_r > ylen;
  assign sts.year_last  = (year_r == YEAR_MAX);
  assign sts.month_more = cnt_r > mlen_ext;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year_r  <= in_year;
      month_r <= in_month;
      day_r   <= in_day;
      ofs_r   <= ofs_sat[OFS_W-1:0];
      quo_r   <= quo_prod[DIV100_SHIFT +: QUO_W];
    end
    if (cmd.residue) begin
      mod100_r <= residue[MOD_W-1:0];
      cent4_r  <= quo_r[1:0];
    end
    if (cmd.check) begin
      if (sts.invalid) begin
        cnt_r <= CNT_W'(day_r);
        err_r <= ERR_INVALID;
      end else begin
        cnt_r <= start_cnt;
        err_r <= ERR_NONE;
      end
    end
    if (cmd.year_step) begin
      cnt_r  <= cnt_r - ylen;
      year_r <= year_r + YEAR_W'(1);
      if (mod100_r == MOD100_LAST) begin
        mod100_r <= '0;
        cent4_r  <= cent4_r + 2'd1;
      end else begin
        mod100_r <= mod100_r + MOD_W'(1);
      end
    end
    if (cmd.overflow) begin
      year_r  <= '0;
      month_r <= '0;
      cnt_r   <= '0;
      err_r   <= ERR_OVERFLOW;
    end
    if (cmd.month_start) begin
      month_r <= MONTH_JAN;
    end
    if (cmd.month_step) begin
      cnt_r   <= cnt_r - mlen_ext;
      month_r <= month_r + MONTH_W'(1);
    end
    if (cmd.out_load) begin
      res_year_r  <= year_r;
      res_month_r <= month_r;
      res_day_r   <= cnt_r[DAY_W-1:0];
      res_err_r   <= err_r;
    end
  end

  assign out_new_year   = res_year_r;
  assign out_new_month  = res_month_r;
  assign out_new_day    = res_day_r;
  assign out_error_code = res_err_r;

endmodule

/* rtl/core/calendar_date_add_days_core.sv */
// Top level of the Gregorian date-add-days core.
//
// Usage:
//   Present a start date (in_year, in_month, in_day) and a forward offset
//   (in_add_days) on the input channel; one transfer yields exactly one
//   result transfer on the output channel (out_new_year, out_new_month,
//   out_new_day, out_error_code). Offsets above MAX_ADD_DAYS saturate.
//   Error code 1 flags an invalid start date and echoes it; error code 2
//   flags a result year past 16383 and returns zeros.
// Sequence:
//   One item at a time. After the input transfer the core forms the residues,
//   lets them settle and checks validity; for a valid date it then walks the
//   whole years crossed and the whole months crossed, and finally loads the
//   output register. The year walk dominates.
// Reset and stall:
//   Reset returns the sequencer to idle and empties the output register.
//   A result waiting in the output register does not block the next input
//   transfer; only the final load waits until the receiver frees it.
`timescale 1ns / 1ps

module calendar_date_add_days_core #(
  parameter int MAX_ADD_DAYS = cdad_pkg::DEF_MAX_ADD_DAYS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cdad_pkg::YEAR_W-1:0]   in_year,
  input  logic [cdad_pkg::MONTH_W-1:0]  in_month,
  input  logic [cdad_pkg::DAY_W-1:0]    in_day,
  input  logic [cdad_pkg::ADD_W-1:0]    in_add_days,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cdad_pkg::YEAR_W-1:0]   out_new_year,
  output logic [cdad_pkg::MONTH_W-1:0]  out_new_month,
  output logic [cdad_pkg::DAY_W-1:0]    out_new_day,
  output logic [cdad_pkg::ERR_W-1:0]    out_error_code
);
  import cdad_pkg::*;

  // Command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns the handshake and the phase of the current item
  cdad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: holds the working date, the remaining day count and the
  // incremental leap-year trackers, plus the output register
  cdad_dpath #(
    .MAX_ADD_DAYS (MAX_ADD_DAYS)
  ) u_dpath (
    .clk            (clk),
    .in_year        (in_year),
    .in_month       (in_month),
    .in_day         (in_day),
    .in_add_days    (in_add_days),
    .cmd            (cmd),
    .sts            (sts),
    .out_new_year   (out_new_year),
    .out_new_month  (out_new_month),
    .out_new_day    (out_new_day),
    .out_error_code (out_error_code)
  );

endmodule
